// File: src/utf8_stream_decoder_macros.svh
// Assertion macros for the UTF-8 stream decoder.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

// Check an implication on every rising edge outside reset.
`define U8D_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Check a plain condition on every rising edge outside reset.
`define U8D_ASSERT_ALWAYS(label, cond, msg) \
	`U8D_ASSERT(label, 1'b1 |-> (cond), msg)

`endif

// File: src/u8d_pkg.sv
// Types and constants of the UTF-8 stream decoder.
// No dependencies; used by utf8_stream_decoder.
package u8d_pkg;

	localparam int unsigned CpW = 21;

	localparam logic [CpW-1:0] ErrMark = 21'h00003F;

	typedef struct packed {
		logic [7:0] byte_in;
		logic       end_of_stream;
	} byte_item_t;

	typedef struct packed {
		logic [CpW-1:0] code_point;
		logic           is_error;
		logic           last_of_run;
	} char_item_t;

	typedef enum logic [2:0] {
		CLS_ASCII,
		CLS_CONT,
		CLS_LEAD2,
		CLS_LEAD3,
		CLS_LEAD4,
		CLS_BAD
	} byte_class_t;

	function automatic byte_class_t classify(input logic [7:0] b);
		byte_class_t c;
		priority if (b <= 8'h7F) c = CLS_ASCII;
		else if (b <= 8'hBF) c = CLS_CONT;
		else if (b <= 8'hDF) c = CLS_LEAD2;
		else if (b <= 8'hEF) c = CLS_LEAD3;
		else if (b <= 8'hF7) c = CLS_LEAD4;
		else c = CLS_BAD;
		return c;
	endfunction

endpackage

// File: src/utf8_stream_decoder.sv
// UTF-8 stream decoder top level: input register, decode, two-slot result buffer.
// Depends on u8d_pkg and utf8_stream_decoder_macros.svh.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+----------------------------
//   byte    | in        | byte_valid / byte_stall  | byte_item (byte, end mark)
//   char    | out       | char_valid / char_stall  | char_item (code point,
//           |           |                          |   error, last of run)
//
// Flow: an item is decoded while it sits in the byte register and its results
// enter the result buffer once they fit there; the buffer head shows on the
// char channel. One item per cycle sustained while no stall holds the flow;
// an item that gives two results takes two slots and leaves them one by one.
// Reset: arst_n clears valids, the buffer count and the decode state at once.
// Stalls: char_stall holds the buffer; byte_stall rises while the registered
// item's results do not fit beside what the buffer still keeps.
`include "utf8_stream_decoder_macros.svh"

module utf8_stream_decoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  u8d_pkg::byte_item_t byte_item,
	output logic                char_valid,
	input  logic                char_stall,
	output u8d_pkg::char_item_t char_item
);

	// Byte register.
	logic                valid_s1;
	u8d_pkg::byte_item_t item_s1;

	// Decode state.
	logic [1:0]                  pending_q;
	logic [u8d_pkg::CpW-1:0]     partial_q;

	// Result buffer: slot 0 is the head shown on the char channel.
	u8d_pkg::char_item_t slot_q [2];
	logic [1:0]          cnt_q;

	// Decode outputs.
	u8d_pkg::char_item_t     res [2];
	logic [1:0]              res_n;
	logic [1:0]              pending_d;
	logic [u8d_pkg::CpW-1:0] partial_d;
	logic [u8d_pkg::CpW-1:0] shifted;
	u8d_pkg::byte_class_t    cls;

	logic       pop;
	logic [1:0] base;
	logic       advance;
	logic       load;

	// ---------------------------------------------------------------
	// Decode the registered byte against the current state.
	// ---------------------------------------------------------------
	always_comb begin
		cls       = u8d_pkg::classify(item_s1.byte_in);
		shifted   = {partial_q[u8d_pkg::CpW-7:0], item_s1.byte_in[5:0]};
		res[0]    = '{code_point: u8d_pkg::ErrMark, is_error: 1'b1, last_of_run: 1'b0};
		res[1]    = '{code_point: u8d_pkg::ErrMark, is_error: 1'b1, last_of_run: 1'b0};
		res_n     = 2'd0;
		pending_d = pending_q;
		partial_d = partial_q;

		unique case (cls)
			u8d_pkg::CLS_ASCII: begin
				// An ASCII byte cuts a pending sequence short: mark it first.
				if (pending_q != 2'd0) begin
					res[1].code_point = {{(u8d_pkg::CpW-8){1'b0}}, item_s1.byte_in};
					res[1].is_error   = 1'b0;
					res_n             = 2'd2;
				end else begin
					res[0].code_point = {{(u8d_pkg::CpW-8){1'b0}}, item_s1.byte_in};
					res[0].is_error   = 1'b0;
					res_n             = 2'd1;
				end
				pending_d = 2'd0;
			end
			u8d_pkg::CLS_CONT: begin
				if (pending_q != 2'd0) begin
					partial_d = shifted;
					pending_d = pending_q - 2'd1;
					if (pending_q == 2'd1) begin
						res[0].code_point = shifted;
						res[0].is_error   = 1'b0;
						res_n             = 2'd1;
					end
				end else begin
					// Stray continuation byte.
					res_n = 2'd1;
				end
			end
			u8d_pkg::CLS_LEAD2: begin
				pending_d = 2'd1;
				partial_d = {{(u8d_pkg::CpW-5){1'b0}}, item_s1.byte_in[4:0]};
			end
			u8d_pkg::CLS_LEAD3: begin
				pending_d = 2'd2;
				partial_d = {{(u8d_pkg::CpW-4){1'b0}}, item_s1.byte_in[3:0]};
			end
			u8d_pkg::CLS_LEAD4: begin
				pending_d = 2'd3;
				partial_d = {{(u8d_pkg::CpW-3){1'b0}}, item_s1.byte_in[2:0]};
			end
			default: begin
				// Bytes that never occur in UTF-8.
				res_n     = 2'd1;
				pending_d = 2'd0;
			end
		endcase

		// End of stream: flag an unfinished sequence, then start fresh.
		if (item_s1.end_of_stream) begin
			if (pending_d != 2'd0) begin
				res_n = res_n + 2'd1;
			end
			pending_d = 2'd0;
			partial_d = '0;
		end

		if (res_n == 2'd2) begin
			res[1].last_of_run = 1'b1;
		end else begin
			res[0].last_of_run = 1'b1;
		end
	end

	// ---------------------------------------------------------------
	// Handshakes: advance the byte register only when its results fit.
	// ---------------------------------------------------------------
	assign char_valid = (cnt_q != 2'd0);
	assign char_item  = slot_q[0];
	assign pop        = char_valid && !char_stall;
	assign base       = cnt_q - {1'b0, pop};
	assign advance    = valid_s1 && ({1'b0, res_n} + {1'b0, base} <= 3'd2);
	assign byte_stall = valid_s1 && !advance;
	assign load       = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= byte_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 2'd0;
			partial_q <= '0;
		end else if (advance) begin
			pending_q <= pending_d;
			partial_q <= partial_d;
		end
	end

	// ---------------------------------------------------------------
	// Result buffer: shift the head out, append new results behind.
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= base + (advance ? res_n : 2'd0);
		end
	end

	always_ff @(posedge clk) begin
		// A new head from decode wins over the shifted one.
		if (advance && base == 2'd0 && res_n != 2'd0) begin
			slot_q[0] <= res[0];
		end else if (pop) begin
			slot_q[0] <= slot_q[1];
		end
		if (advance && base == 2'd0 && res_n == 2'd2) begin
			slot_q[1] <= res[1];
		end else if (advance && base == 2'd1 && res_n == 2'd1) begin
			slot_q[1] <= res[0];
		end
	end

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	`U8D_ASSERT_ALWAYS(a_cnt_bound, cnt_q != 2'd3, "result buffer count beyond two")
	`U8D_ASSERT(a_stall_needs_item, byte_stall |-> valid_s1 && (res_n != 2'd0),
		"byte stall without a pending result-giving item")
	`U8D_ASSERT(a_eos_clears, advance && item_s1.end_of_stream |=>
		pending_q == 2'd0 && partial_q == '0, "state not cleared after end of stream")
	`U8D_ASSERT(a_head_has_last, char_valid && cnt_q == 2'd1 |-> slot_q[0].last_of_run,
		"lone buffered result lacks last of run")

endmodule

// File: tb/utf8_stream_decoder_tb.sv
`timescale 1ns / 100ps
// Testbench for utf8_stream_decoder: directed and random byte streams, checked
// against a local decoder model. Depends on u8d_pkg and the decoder RTL.
module utf8_stream_decoder_tb;

	localparam int ItemTarget  = 550;   // bytes to send at least over the whole run
	localparam int IdleLimit   = 1000;  // cycles with no item moving on either side
	localparam int DrainCycles = 8;     // byte register -> decode -> result buffer, plus margin

	// Receiver stall patterns; each one lasts for a random number of cycles.
	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                byte_valid = 1'b0;
	logic                byte_stall;
	u8d_pkg::byte_item_t byte_item  = '0;
	logic                char_valid;
	logic                char_stall = 1'b0;
	u8d_pkg::char_item_t char_item;

	// Decoder state as this bench sees it; starts cleared, like the block after reset.
	logic [1:0]              pend_cnt   = 2'd0;
	logic [u8d_pkg::CpW-1:0] partial_cp = '0;

	// Characters the block still owes us, oldest first.
	u8d_pkg::char_item_t expected_chars [$];

	int          fail_count  = 0;
	int          bytes_sent  = 0;
	int          burst_left  = 0;
	int          idle_cycles = 0;
	int          stall_hold  = 0;
	stall_mode_t stall_mode  = STALL_NONE;
	bit          calm        = 1'b0;  // set to run a stretch with no idling on either side

	utf8_stream_decoder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_item (byte_item),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_item (char_item)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Decode one accepted byte and queue the characters it must produce.
	function automatic void decode_byte(input logic [7:0] b, input logic eos);
		u8d_pkg::char_item_t  res [2];
		u8d_pkg::char_item_t  err_mark;
		u8d_pkg::byte_class_t cls;
		int                   n;
		err_mark = '{code_point: u8d_pkg::ErrMark, is_error: 1'b1, last_of_run: 1'b0};
		n = 0;
		if (b <= 8'h7F) cls = u8d_pkg::CLS_ASCII;
		else if (b <= 8'hBF) cls = u8d_pkg::CLS_CONT;
		else if (b <= 8'hDF) cls = u8d_pkg::CLS_LEAD2;
		else if (b <= 8'hEF) cls = u8d_pkg::CLS_LEAD3;
		else if (b <= 8'hF7) cls = u8d_pkg::CLS_LEAD4;
		else cls = u8d_pkg::CLS_BAD;

		case (cls)
			u8d_pkg::CLS_ASCII: begin
				// An ASCII byte cuts a pending sequence short: mark it, then the character.
				if (pend_cnt != 2'd0) begin
					res[n] = err_mark;
					n++;
					pend_cnt = 2'd0;
				end
				res[n] = '{code_point: {{(u8d_pkg::CpW-8){1'b0}}, b}, is_error: 1'b0,
				           last_of_run: 1'b0};
				n++;
			end
			u8d_pkg::CLS_CONT: begin
				if (pend_cnt != 2'd0) begin
					// Shift six payload bits in; the top bits fall off the 21-bit value.
					partial_cp = {partial_cp[u8d_pkg::CpW-7:0], b[5:0]};
					pend_cnt   = pend_cnt - 2'd1;
					if (pend_cnt == 2'd0) begin
						res[n] = '{code_point: partial_cp, is_error: 1'b0,
						           last_of_run: 1'b0};
						n++;
					end
				end else begin
					// Stray continuation with nothing pending.
					res[n] = err_mark;
					n++;
				end
			end
			// A lead byte drops whatever was pending without a mark.
			u8d_pkg::CLS_LEAD2: begin
				pend_cnt   = 2'd1;
				partial_cp = {{(u8d_pkg::CpW-5){1'b0}}, b[4:0]};
			end
			u8d_pkg::CLS_LEAD3: begin
				pend_cnt   = 2'd2;
				partial_cp = {{(u8d_pkg::CpW-4){1'b0}}, b[3:0]};
			end
			u8d_pkg::CLS_LEAD4: begin
				pend_cnt   = 2'd3;
				partial_cp = {{(u8d_pkg::CpW-3){1'b0}}, b[2:0]};
			end
			default: begin
				res[n] = err_mark;
				n++;
				pend_cnt = 2'd0;
			end
		endcase

		// End of stream: mark an unfinished sequence, then start clean.
		if (eos) begin
			if (pend_cnt != 2'd0) begin
				res[n] = err_mark;
				n++;
			end
			pend_cnt   = 2'd0;
			partial_cp = '0;
		end

		if (n > 0)
			res[n-1].last_of_run = 1'b1;
		for (int i = 0; i < n; i++)
			expected_chars.insert(expected_chars.size(), res[i]);
	endfunction

	// Present one byte, hold it until accepted, then predict its characters.
	// Gaps fall only between bursts; valid stays high from one item to the next.
	task automatic send_byte(input logic [7:0] b, input logic eos);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = (calm || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
			if (gap > 0) begin
				byte_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		byte_valid <= 1'b1;
		byte_item  <= '{byte_in: b, end_of_stream: eos};
		do
			@(posedge clk);
		while (byte_stall);
		bytes_sent++;
		decode_byte(b, eos);
	endtask

	// Drive the receiver stall: pick a new random pattern whenever the hold runs out.
	always @(posedge clk) begin
		if (stall_hold == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_hold = $urandom_range(16, 64);
		end else begin
			stall_hold--;
		end
		if (calm) begin
			char_stall <= 1'b0;
		end else begin
			case (stall_mode)
				STALL_NONE:     char_stall <= 1'b0;
				STALL_LIGHT:    char_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY:    char_stall <= ($urandom_range(0, 1) == 0);
				default:        char_stall <= (stall_hold[2:0] < 3'd5);
			endcase
		end
	end

	// Check each accepted character against the oldest one owed; run the watchdog.
	always @(posedge clk) begin
		u8d_pkg::char_item_t want;
		if (arst_n) begin
			if (char_valid && !char_stall) begin
				if (expected_chars.size() == 0) begin
					$display("%0t: unexpected char: expected none, got cp %h err %b last %b",
					         $time, char_item.code_point, char_item.is_error,
					         char_item.last_of_run);
					fail_count++;
				end else begin
					want = expected_chars.pop_front();
					if (char_item.code_point !== want.code_point) begin
						$display("%0t: code_point expected %h got %h",
						         $time, want.code_point, char_item.code_point);
						fail_count++;
					end
					if (char_item.is_error !== want.is_error) begin
						$display("%0t: is_error expected %b got %b (cp %h)",
						         $time, want.is_error, char_item.is_error, want.code_point);
						fail_count++;
					end
					if (char_item.last_of_run !== want.last_of_run) begin
						$display("%0t: last_of_run expected %b got %b (cp %h)",
						         $time, want.last_of_run, char_item.last_of_run,
						         want.code_point);
						fail_count++;
					end
				end
			end

			if ((byte_valid && !byte_stall) || (char_valid && !char_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IdleLimit) begin
				$display("%0t: watchdog: no item moved for %0d cycles", $time, IdleLimit);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// Lowest and highest ASCII, plus a literal '?' that must not read as an error.
	task automatic test_ascii_extremes();
		send_byte(8'h00, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'h3F, 1'b0);
	endtask

	// Both ends of the two-byte payload, top of three- and four-byte, no range checks.
	task automatic test_multibyte_extremes();
		send_byte(8'hC0, 1'b0); send_byte(8'h80, 1'b0);
		send_byte(8'hDF, 1'b0); send_byte(8'hBF, 1'b0);
		send_byte(8'hEF, 1'b0); send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);
		send_byte(8'hF7, 1'b0); send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);
		send_byte(8'hBF, 1'b0);
	endtask

	// Malformed input: stray continuation, ASCII cutting in, lead byte taking over,
	// and the never-valid bytes both alone and in the middle of a sequence.
	task automatic test_malformed();
		send_byte(8'h80, 1'b0);
		send_byte(8'hE2, 1'b0); send_byte(8'h41, 1'b0);
		send_byte(8'hC3, 1'b0); send_byte(8'hC2, 1'b0); send_byte(8'hA9, 1'b0);
		send_byte(8'hE2, 1'b0); send_byte(8'hFF, 1'b0);
		send_byte(8'hF8, 1'b0);
	endtask

	// Stream ends with a sequence open, on a continuation and on a lead byte.
	task automatic test_end_of_stream();
		send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b1);
		send_byte(8'hF0, 1'b1);
	endtask

	// Mostly well-formed characters with random payload; the rest truncated
	// sequences and raw noise. End marks land now and then, anywhere.
	task automatic test_random_stream();
		logic [7:0]              seq [4];
		int                      seq_len;
		logic [31:0]             rnd;
		logic [u8d_pkg::CpW-1:0] cp;
		int                      kind;
		bit                      eos_at_end;
		while (bytes_sent < ItemTarget) begin
			rnd     = $urandom;
			cp      = rnd[u8d_pkg::CpW-1:0];
			kind    = int'($urandom_range(0, 99));
			seq_len = 0;
			if (kind < 25) begin
				seq[0]  = {1'b0, cp[6:0]};
				seq_len = 1;
			end else if (kind < 45) begin
				seq[0]  = {3'b110, cp[10:6]};
				seq[1]  = {2'b10, cp[5:0]};
				seq_len = 2;
			end else if (kind < 65) begin
				seq[0]  = {4'b1110, cp[15:12]};
				seq[1]  = {2'b10, cp[11:6]};
				seq[2]  = {2'b10, cp[5:0]};
				seq_len = 3;
			end else if (kind < 88) begin
				seq[0]  = {5'b11110, cp[20:18]};
				seq[1]  = {2'b10, cp[17:12]};
				seq[2]  = {2'b10, cp[11:6]};
				seq[3]  = {2'b10, cp[5:0]};
				seq_len = 4;
				// Cut some short so ASCII, lead or end mark hits a pending sequence.
				if (kind >= 80)
					seq_len = seq_len - int'($urandom_range(1, 3));
			end else begin
				seq_len = int'($urandom_range(1, 3));
				for (int i = 0; i < seq_len; i++)
					seq[i] = 8'($urandom_range(0, 255));
			end

			eos_at_end = ($urandom_range(0, 19) == 0);
			for (int i = 0; i < seq_len; i++)
				send_byte(seq[i], (eos_at_end && i == seq_len - 1) ||
				                  ($urandom_range(0, 63) == 0));

			// Switch idling off and on now and then.
			if ($urandom_range(0, 39) == 0)
				calm = !calm;
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_ascii_extremes();
		test_multibyte_extremes();
		test_malformed();
		test_end_of_stream();
		test_random_stream();

		// Drop valid after the last item and drain what is still owed.
		byte_valid <= 1'b0;
		calm = 1'b0;
		while (expected_chars.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
